// File: rtl/fat_chain_block_allocator_unit_defines.svh
// assertion macros used by the allocator top level
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define FCBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcba same-cycle check failed");

// next-cycle implication, ignored while in reset
`define FCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcba next-cycle check failed");

`endif

// File: rtl/fcba_pkg.sv
// types and codes for the chain block allocator
`timescale 1ns / 1ps

package fcba_pkg;

    localparam logic [1:0] MODE_FORMAT = 2'd0;
    localparam logic [1:0] MODE_ALLOC  = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;
    localparam logic [1:0] MODE_FOLLOW = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_START_FREE = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] block_count;
        logic [7:0] block_index;
    } fcba_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] first_block;
        logic [8:0] blocks_done;
        logic [7:0] next_block;
        logic       is_end;
        logic       is_free;
    } fcba_rsp_t;

endpackage

// File: rtl/fcba_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fcba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/fat_chain_block_allocator_unit.sv
// top level of the chain block allocator: sequencer around one link table ram
`timescale 1ns / 1ps
`include "fat_chain_block_allocator_unit_defines.svh"

// Chain block allocator. Holds a table of NUM_BLOCKS link entries, each free,
// end of chain, or pointing to the next block, in one ram with a single write
// port and one registered read port. Every request runs one of four modes and
// gives exactly one response. Format clears all entries to free. Allocate
// builds a chain of block_count blocks from the lowest free entries upwards,
// ending early with no-space status if the table runs out. Free walks a chain
// from block_index and releases each entry. Follow reports one entry. Every
// mode shares the one ram port pair. Allocate makes one linear scan of the
// table, one entry per cycle, and free visits one chain entry per cycle.
// After reset the table is swept to free with req_ready low. A new request
// is taken while the previous response still waits in the output register.
module fat_chain_block_allocator_unit #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  fcba_pkg::fcba_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fcba_pkg::fcba_rsp_t rsp_data
);

    import fcba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int ENT_W = IDX_W + 2;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    // entry layout: free flag, end flag, next block index
    localparam logic [ENT_W-1:0] ENT_FREE = {2'b10, {IDX_W{1'b0}}};
    localparam logic [ENT_W-1:0] ENT_END  = {2'b01, {IDX_W{1'b0}}};

    localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(NUM_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(NUM_BLOCKS);

    typedef enum logic [6:0] {
        S_CLEAR     = 7'b0000001,
        S_IDLE      = 7'b0000010,
        S_ALLOC     = 7'b0000100,
        S_ALLOC_END = 7'b0001000,
        S_FREE      = 7'b0010000,
        S_FOLLOW    = 7'b0100000,
        S_FINISH    = 7'b1000000
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic             fmt_reg, fmt_next;
    logic [IDX_W:0]   scan_addr_reg, scan_addr_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             have_cur_reg, have_cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload
    logic [IDX_W-1:0] chk_addr_reg, chk_addr_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [8:0]       count_reg, count_next;
    fcba_rsp_t        res_reg, res_next;
    fcba_rsp_t        rsp_reg, rsp_next;

    // ram port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic             rd_free;
    logic             rd_end;
    logic [IDX_W-1:0] rd_next;
    logic             req_oob;
    logic             rsp_load;
    logic [CNT_W-1:0] cnt_inc;

    fcba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_free = ram_rdata[IDX_W+1];
    assign rd_end  = ram_rdata[IDX_W];
    assign rd_next = ram_rdata[IDX_W-1:0];

    // block index beyond the table reads as a free entry
    assign req_oob = (32'(req_data.block_index) >= NUM_BLOCKS);
    assign cnt_inc = cnt_reg + 1'b1;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_load  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        fmt_next       = fmt_reg;
        scan_addr_next = scan_addr_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        have_cur_next  = have_cur_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = ENT_END;
        ram_raddr = scan_addr_reg[IDX_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                // one entry per cycle, used after reset and by format
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = ENT_FREE;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = fmt_reg ? S_FINISH : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next = '0;
                    cnt_next = '0;
                    cur_next = IDX_W'(req_data.block_index);
                    case (req_data.mode)
                        MODE_FORMAT:
                        begin
                            clr_addr_next = '0;
                            fmt_next      = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        MODE_ALLOC:
                        begin
                            count_next     = req_data.block_count;
                            scan_addr_next = '0;
                            chk_valid_next = 1'b0;
                            have_cur_next  = 1'b0;
                            state_next     = (req_data.block_count == 9'd0) ? S_FINISH
                                                                           : S_ALLOC;
                        end
                        MODE_FREE:
                        begin
                            ram_raddr = IDX_W'(req_data.block_index);
                            if (req_oob)
                            begin
                                res_next.status = ST_START_FREE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        MODE_FOLLOW:
                        begin
                            ram_raddr = IDX_W'(req_data.block_index);
                            if (req_oob)
                            begin
                                res_next.is_free = 1'b1;
                                state_next       = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_FOLLOW;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                // issue side: one read per cycle, ascending
                if (scan_addr_reg < SCAN_END)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_addr_reg[IDX_W-1:0];
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end

                // check side: every free entry found extends the chain
                if (chk_valid_reg && rd_free)
                begin
                    cur_next = chk_addr_reg;
                    cnt_next = cnt_inc;
                    if (!have_cur_reg)
                    begin
                        have_cur_next        = 1'b1;
                        res_next.first_block = 8'(chk_addr_reg);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_reg;
                        ram_wdata = {2'b00, chk_addr_reg};
                    end
                    if (CMP_W'(cnt_inc) == CMP_W'(count_reg))
                    begin
                        state_next = S_ALLOC_END;
                    end
                end
                else if (!chk_valid_reg && (scan_addr_reg == SCAN_END))
                begin
                    // table exhausted before the count was reached
                    res_next.status = ST_NO_SPACE;
                    state_next      = have_cur_reg ? S_ALLOC_END : S_FINISH;
                end
            end

            S_ALLOC_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = ENT_END;
                res_next.blocks_done = 9'(cnt_reg);
                state_next = S_FINISH;
            end

            S_FREE:
            begin
                // read data holds the entry at cur_reg
                if (rd_free)
                begin
                    if (cnt_reg == '0)
                    begin
                        res_next.status = ST_START_FREE;
                    end
                    res_next.blocks_done = 9'(cnt_reg);
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = ENT_FREE;
                    cnt_next  = cnt_inc;
                    ram_raddr = rd_next;
                    cur_next  = rd_next;
                    if (rd_end || (cnt_inc == CNT_MAX))
                    begin
                        res_next.blocks_done = 9'(cnt_inc);
                        state_next = S_FINISH;
                    end
                end
            end

            S_FOLLOW:
            begin
                if (rd_free)
                begin
                    res_next.is_free = 1'b1;
                end
                else if (rd_end)
                begin
                    res_next.is_end = 1'b1;
                end
                else
                begin
                    res_next.next_block = 8'(rd_next);
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (rsp_load)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    fmt_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            fmt_reg       <= 1'b0;
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
            have_cur_reg  <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fmt_reg       <= fmt_next;
            scan_addr_reg <= scan_addr_next;
            chk_valid_reg <= chk_valid_next;
            have_cur_reg  <= have_cur_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        cur_reg      <= cur_next;
        count_reg    <= count_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    // no table writes while waiting for a request
    `FCBA_ASSERT_IMPL(a_idle_no_write, clk, rst_n, req_ready, !ram_we)

    // chain links only ever point to a higher block
    `FCBA_ASSERT_IMPL(a_link_ascends, clk, rst_n,
        ram_we && (state_reg == S_ALLOC), ram_wdata[IDX_W-1:0] > ram_waddr)

    // allocation stops scanning as soon as the count is met
    `FCBA_ASSERT_IMPL(a_alloc_below_count, clk, rst_n,
        state_reg == S_ALLOC, CMP_W'(cnt_reg) < CMP_W'(count_reg))

    // a walk never releases more than the table holds
    `FCBA_ASSERT_IMPL(a_free_bounded, clk, rst_n,
        state_reg == S_FREE, cnt_reg < CNT_MAX)

    // a finished response lands in the output register and frees the block
    `FCBA_ASSERT_NEXT(a_finish_loads, clk, rst_n,
        rsp_load, rsp_valid_reg && (state_reg == S_IDLE))

endmodule

// File: tb/fcba_checker.sv
// response checker for the chain block allocator: table predictor and comparison
`timescale 1ns / 1ps

module fcba_checker
    import fcba_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  fcba_req_t req_data,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  fcba_rsp_t rsp_data,
    output int        fail_count,
    output int        answers_pending
);

    typedef enum logic [1:0] {SLOT_FREE, SLOT_END, SLOT_LINK} slot_kind_t;

    typedef struct packed {
        slot_kind_t kind;
        logic [7:0] next;
    } slot_t;

    slot_t     slots [NUM_BLOCKS];
    fcba_rsp_t awaited_answers [$];
    int        fails;

    function automatic void clear_slots();
        for (int i = 0; i < NUM_BLOCKS; i++)
            slots[i] = '{kind: SLOT_FREE, next: 8'd0};
    endfunction

    // lowest free slot other than skip, NUM_BLOCKS when the table is full
    function automatic int lowest_free_except(int skip);
        for (int i = 0; i < NUM_BLOCKS; i++)
            if (slots[i].kind == SLOT_FREE && i != skip)
                return i;
        return NUM_BLOCKS;
    endfunction

    // applies one request to the shadow table and gives the answer it earns
    function automatic fcba_rsp_t table_answer(fcba_req_t r);
        fcba_rsp_t a;
        int        cur;
        int        nb;
        int        done;
        int        idx;
        slot_t     e;
        bit        walking;
        a       = '0;
        done    = 0;
        idx     = int'(r.block_index);
        case (r.mode)
            MODE_FORMAT: clear_slots();
            MODE_ALLOC:
            begin
                if (r.block_count != 0)
                begin
                    cur = lowest_free_except(NUM_BLOCKS);
                    if (cur >= NUM_BLOCKS)
                        a.status = ST_NO_SPACE;
                    else
                    begin
                        a.first_block = 8'(cur);
                        for (int j = 0; j < int'(r.block_count); j++)
                        begin
                            if (j + 1 == int'(r.block_count))
                            begin
                                slots[cur] = '{kind: SLOT_END, next: 8'd0};
                                done = j + 1;
                                break;
                            end
                            nb = lowest_free_except(cur);
                            if (nb >= NUM_BLOCKS)
                            begin
                                // out of room mid-chain: close the chain here
                                slots[cur] = '{kind: SLOT_END, next: 8'd0};
                                a.status   = ST_NO_SPACE;
                                done = j + 1;
                                break;
                            end
                            slots[cur] = '{kind: SLOT_LINK, next: 8'(nb)};
                            cur = nb;
                        end
                    end
                end
            end
            MODE_FREE:
            begin
                if (idx >= NUM_BLOCKS || slots[idx].kind == SLOT_FREE)
                    a.status = ST_START_FREE;
                else
                begin
                    cur     = idx;
                    walking = 1'b1;
                    while (walking && done < NUM_BLOCKS && cur < NUM_BLOCKS &&
                           slots[cur].kind != SLOT_FREE)
                    begin
                        e          = slots[cur];
                        slots[cur] = '{kind: SLOT_FREE, next: 8'd0};
                        done++;
                        if (e.kind == SLOT_END)
                            walking = 1'b0;
                        else
                            cur = int'(e.next);
                    end
                end
            end
            default:
            begin
                if (idx >= NUM_BLOCKS || slots[idx].kind == SLOT_FREE)
                    a.is_free = 1'b1;
                else if (slots[idx].kind == SLOT_END)
                    a.is_end = 1'b1;
                else
                    a.next_block = slots[idx].next;
            end
        endcase
        a.blocks_done = 9'(done);
        return a;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fcba_rsp_t want;
        if (!rst_n)
        begin
            clear_slots();
            awaited_answers.delete();
            fails = 0;
            fail_count      <= 0;
            answers_pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("response with no request waiting");
                    fails++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_data.status));
                    check_field("first_block", 32'(want.first_block),
                                32'(rsp_data.first_block));
                    check_field("blocks_done", 32'(want.blocks_done),
                                32'(rsp_data.blocks_done));
                    check_field("next_block", 32'(want.next_block),
                                32'(rsp_data.next_block));
                    check_field("is_end", 32'(want.is_end), 32'(rsp_data.is_end));
                    check_field("is_free", 32'(want.is_free), 32'(rsp_data.is_free));
                end
            end
            if (req_valid && req_ready)
                awaited_answers.push_back(table_answer(req_data));
            fail_count      <= fails;
            answers_pending <= awaited_answers.size();
        end
    end

endmodule

// File: tb/tb_fat_chain_block_allocator_unit.sv
// testbench top for the chain block allocator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_fat_chain_block_allocator_unit;
    import fcba_pkg::*;

    localparam int NUM_BLOCKS     = 256;
    localparam int RANDOM_PER_PHASE = 400;
    // worst single request is a full-table scan plus the response stall,
    // and the sweep after reset; this is several times that
    localparam int QUIET_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 300;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    fcba_req_t req_data  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    fcba_rsp_t rsp_data;

    int fails;
    int answers_pending;

    // flow-control knobs, percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;

    // bookkeeping used only to shape stimulus and the summary
    logic [1:0] sent_modes [$];
    logic [7:0] chain_heads [$];
    int         requests_sent  = 0;
    int         directed_sent  = 0;
    int         responses_seen = 0;
    int         no_space_seen  = 0;
    int         quiet_cycles   = 0;

    fat_chain_block_allocator_unit #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    fcba_checker #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .fail_count     (fails),
        .answers_pending(answers_pending)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // response side back-pressure, redrawn every cycle
    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

    // learn chain heads from allocate answers so frees can hit real chains
    always @(posedge clk)
    begin
        logic [1:0] m;
        if (rst_n && rsp_valid && rsp_ready && sent_modes.size() != 0)
        begin
            m = sent_modes.pop_front();
            responses_seen++;
            if (m == MODE_ALLOC && rsp_data.status == ST_NO_SPACE)
                no_space_seen++;
            if (m == MODE_ALLOC && rsp_data.blocks_done != 0 && chain_heads.size() < 64)
                chain_heads.push_back(rsp_data.first_block);
        end
    end

    // watchdog: too long without any handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic fcba_req_t make_request(logic [1:0] m, int count, int idx);
        fcba_req_t r;
        r.mode        = m;
        r.block_count = 9'(count);
        r.block_index = 8'(idx);
        return r;
    endfunction

    // one request: optional idle gap, then hold valid until the dut takes it
    task automatic send_request(input fcba_req_t r);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sent_modes.push_back(r.mode);
        requests_sent++;
        // a format wipes every chain, so forget the heads we knew
        if (r.mode == MODE_FORMAT)
            chain_heads.delete();
    endtask

    // random request, weighted so the table fills, drains and fragments
    function automatic fcba_req_t random_request();
        fcba_req_t r;
        int        sel;
        int        p;
        int        k;
        r.mode        = MODE_FOLLOW;
        r.block_count = 9'($urandom_range(0, 511));
        r.block_index = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 3)
            r.mode = MODE_FORMAT;
        else if (sel < 40)
        begin
            r.mode = MODE_ALLOC;
            p = $urandom_range(0, 99);
            // mostly short chains, a few long ones and the odd zero count
            if (p < 2)
                r.block_count = 9'd0;
            else if (p < 80)
                r.block_count = 9'($urandom_range(1, 8));
            else if (p < 95)
                r.block_count = 9'($urandom_range(9, 64));
            else
                r.block_count = 9'($urandom_range(65, 511));
        end
        else if (sel < 70)
        begin
            r.mode = MODE_FREE;
            // usually release a known chain head, otherwise any block,
            // which may land mid-chain or on a free entry
            if (chain_heads.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, chain_heads.size() - 1);
                r.block_index = chain_heads[k];
                chain_heads.delete(k);
            end
        end
        else if (chain_heads.size() != 0 && $urandom_range(0, 1) == 1)
            r.block_index = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        return r;
    endfunction

    // short hand-picked sequence over the corner cases
    task automatic run_directed();
        send_request(make_request(MODE_FOLLOW, 0, 0));      // untouched entry is free
        send_request(make_request(MODE_FOLLOW, 511, 255));  // top index, widest count bits
        send_request(make_request(MODE_FREE, 0, 7));        // free of a free start
        send_request(make_request(MODE_ALLOC, 0, 0));       // zero count does nothing
        send_request(make_request(MODE_ALLOC, 1, 0));       // single block chain at 0
        send_request(make_request(MODE_FOLLOW, 0, 0));      // end of chain
        send_request(make_request(MODE_ALLOC, 3, 0));       // chain 1 -> 2 -> 3
        send_request(make_request(MODE_FOLLOW, 0, 1));      // link to 2
        send_request(make_request(MODE_FREE, 0, 2));        // release the tail part
        send_request(make_request(MODE_FREE, 0, 1));        // walk stops on a free entry
        send_request(make_request(MODE_ALLOC, 256, 0));     // runs out mid-chain
        send_request(make_request(MODE_ALLOC, 1, 0));       // table already full
        send_request(make_request(MODE_FOLLOW, 0, 254));
        send_request(make_request(MODE_FOLLOW, 0, 255));
        send_request(make_request(MODE_FREE, 0, 1));        // long release
        send_request(make_request(MODE_FREE, 0, 0));
        send_request(make_request(MODE_FORMAT, 0, 0));
        send_request(make_request(MODE_ALLOC, 511, 255));   // widest count, ends at 256 blocks
        send_request(make_request(MODE_FOLLOW, 0, 128));
        send_request(make_request(MODE_FORMAT, 511, 255));
        send_request(make_request(MODE_ALLOC, 256, 0));     // exactly fills the table
        send_request(make_request(MODE_FREE, 0, 0));        // whole table in one walk
        send_request(make_request(MODE_ALLOC, 2, 170));
        send_request(make_request(MODE_FOLLOW, 85, 0));
        directed_sent = requests_sent;
    endtask

    initial
    begin
        int gap_tab   [4] = '{0, 52, 0, 22};
        int stall_tab [4] = '{0, 0, 52, 22};

        // reset once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // the dut sweeps its table after reset with req_ready low;
        // send_request simply waits for ready
        run_directed();

        // four flow-control phases: none, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct   = gap_tab[ph];
            stall_pct = stall_tab[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request());
        end
        req_valid <= 1'b0;

        // let the last acceptance reach the checker, then drain
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d requests (%0d directed) under four flow-control phases",
                 requests_sent, directed_sent);
        $display("%0d responses compared, %0d allocations reported no space",
                 responses_seen, no_space_seen);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
